// ===== design/stq_pkg.sv =====
// Package for the smallest-three quaternion quantizer.
// Holds the fixed-point constants and pipeline depths; no dependencies.
package stq_pkg;

    // Width of a scale factor and of its split for the partial products
    localparam int STQ_KW    = 41;
    localparam int STQ_KLO_W = 20;
    localparam int STQ_KHI_W = STQ_KW - STQ_KLO_W;

    // Width of a component after negation (holds +32768)
    localparam int STQ_GW = 17;

    // Quotient bits produced by the divider; 1024 is the saturation value
    localparam int STQ_QB = 11;
    localparam logic [STQ_QB-1:0] STQ_QMAX = 11'd1024;

    // Divider stages (two quotient bits per stage) and lane latency
    localparam int STQ_DIV_STAGES = (STQ_QB + 1) / 2;
    localparam int STQ_LANE_LAT   = STQ_DIV_STAGES + 3;

    // Limits and scale factors, 32 fraction bits
    localparam longint STQ_LIM_POS = 64'sd3025137217;
    localparam longint STQ_LIM_NEG = 64'sd3037000500;
    localparam logic [STQ_KW-1:0] STQ_SCALE = 41'd1557978296627;
    localparam logic [STQ_KW-1:0] STQ_KPOS  = 41'd1097353670758;
    localparam logic [STQ_KW-1:0] STQ_KNEG  = 41'd1101657018486;

endpackage

// ===== design/stq_lane.sv =====
// One quantizer lane: scale multiply, pipelined restoring divide, code mapping.
// Depends on stq_pkg.
module stq_lane
    import stq_pkg::*;
#(
    parameter int DIV_W = 17
)
(
    input  logic                     clk,
    input  logic signed [STQ_GW-1:0] g,
    input  logic [STQ_KW-1:0]        k,
    input  logic [DIV_W-1:0]         vmag,
    output logic [8:0]               code
);

    localparam int PW = ((58 > DIV_W + 31) ? 58 : DIV_W + 31) + 1;
    localparam int TW = PW - 32;
    localparam int CW = ((TW > DIV_W + STQ_QB) ? TW : DIV_W + STQ_QB) + 1;
    localparam int NS = STQ_DIV_STAGES;

    // Stage A: partial products
    logic [STQ_GW-1:0]              mag;
    logic [STQ_GW+STQ_KHI_W-1:0]    phi_a_reg;
    logic [STQ_GW+STQ_KLO_W-1:0]    plo_a_reg;
    logic [DIV_W-1:0]               vmag_a_reg;
    logic                           sgn_a_reg;

    assign mag = g[STQ_GW-1] ? STQ_GW'(-g) : STQ_GW'(g);

    always_ff @(posedge clk)
    begin
        phi_a_reg  <= (STQ_GW+STQ_KHI_W)'(mag) * (STQ_GW+STQ_KHI_W)'(k[STQ_KW-1:STQ_KLO_W]);
        plo_a_reg  <= (STQ_GW+STQ_KLO_W)'(mag) * (STQ_GW+STQ_KLO_W)'(k[STQ_KLO_W-1:0]);
        vmag_a_reg <= vmag;
        sgn_a_reg  <= g[STQ_GW-1];
    end

    // Stage B: add rounding term, drop the 32 fraction bits
    logic [PW-1:0]    sum_b;
    logic [TW-1:0]    t_b_reg;
    logic [DIV_W-1:0] vmag_b_reg;
    logic             sgn_b_reg;

    assign sum_b = (PW'(phi_a_reg) << STQ_KLO_W) + PW'(plo_a_reg) + (PW'(vmag_a_reg) << 31);

    always_ff @(posedge clk)
    begin
        t_b_reg    <= sum_b[PW-1:32];
        vmag_b_reg <= vmag_a_reg;
        sgn_b_reg  <= sgn_a_reg;
    end

    // Divider stages: two quotient bits each
    logic [TW-1:0]     rem_reg  [NS];
    logic [STQ_QB-1:0] q_reg    [NS];
    logic              sat_reg  [NS];
    logic              sgn_reg  [NS];
    logic [DIV_W-1:0]  dv_reg   [NS];

    logic [TW-1:0]     rem_in   [NS];
    logic [STQ_QB-1:0] q_in     [NS];
    logic              sat_in   [NS];
    logic              sgn_in   [NS];
    logic [DIV_W-1:0]  dv_in    [NS];
    logic [TW-1:0]     rem_next [NS];
    logic [STQ_QB-1:0] q_next   [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_div
            if (s == 0)
            begin : g_first
                assign rem_in[s] = t_b_reg;
                assign q_in[s]   = '0;
                assign sat_in[s] = CW'(t_b_reg) >= (CW'(vmag_b_reg) << STQ_QB);
                assign sgn_in[s] = sgn_b_reg;
                assign dv_in[s]  = vmag_b_reg;
            end
            else
            begin : g_rest
                assign rem_in[s] = rem_reg[s-1];
                assign q_in[s]   = q_reg[s-1];
                assign sat_in[s] = sat_reg[s-1];
                assign sgn_in[s] = sgn_reg[s-1];
                assign dv_in[s]  = dv_reg[s-1];
            end

            always_comb
            begin
                int          j;
                logic [CW-1:0] d;
                rem_next[s] = rem_in[s];
                q_next[s]   = q_in[s];
                for (int i = 0; i < 2; i++)
                begin
                    j = STQ_QB - 1 - (2 * s + i);
                    d = CW'(dv_in[s]) << j;
                    if (j >= 0 && CW'(rem_next[s]) >= d)
                    begin
                        rem_next[s] = rem_next[s] - TW'(d);
                        q_next[s]   = q_next[s] | (STQ_QB'(1) << j);
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                sat_reg[s] <= sat_in[s];
                sgn_reg[s] <= sgn_in[s];
                dv_reg[s]  <= dv_in[s];
            end
        end
    endgenerate

    // Output stage: clamp, offset by 256, saturate to 9 bits
    logic [STQ_QB-1:0] q_c;
    logic [8:0]        code_next;
    logic [8:0]        code_reg;

    assign q_c = (sat_reg[NS-1] || q_reg[NS-1] > STQ_QMAX) ? STQ_QMAX : q_reg[NS-1];

    always_comb
    begin
        if (sgn_reg[NS-1])
            code_next = (q_c >= STQ_QB'(256)) ? 9'd0 : 9'(STQ_QB'(256) - q_c);
        else
            code_next = (q_c >= STQ_QB'(255)) ? 9'd511 : 9'(STQ_QB'(256) + q_c);
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

// ===== design/smallest_three_quantizer_top.sv =====
// Smallest-three quaternion quantizer, top level.
// Depends on stq_pkg and stq_lane.
//
// Usage:
//   Drive comp_0..comp_3 (signed, INPUT_FRAC_BITS fraction bits) and pulse
//   start; a transaction is taken on every rising edge with start high and
//   busy low. busy stays low: the block is fully pipelined and takes one
//   transaction per clock, back to back, without limit.
//   Each transaction gives one result: done is high for one cycle together
//   with drop_index and the three 9-bit codes small_a, small_b, small_c.
//   Pipeline: input stage (largest search), select stage (drop, negate,
//   limit check, pick scale factor and divisor), then three identical lanes
//   of multiply, round, six two-bit divider stages and code mapping. The
//   divider sets the depth; one quotient bit pair per stage.
//   The receiver cannot stall: results are strobed and must be taken.
//   Reset clears the valid bits only, so no stray done follows reset;
//   payload registers keep whatever they hold.
module smallest_three_quantizer_top
    import stq_pkg::*;
#(
    parameter int INPUT_FRAC_BITS = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] comp_0,
    input  logic signed [15:0] comp_1,
    input  logic signed [15:0] comp_2,
    input  logic signed [15:0] comp_3,
    output logic               done,
    output logic [1:0]         drop_index,
    output logic [8:0]         small_a,
    output logic [8:0]         small_b,
    output logic [8:0]         small_c
);

    localparam int DIV_W = (INPUT_FRAC_BITS + 1 > STQ_GW) ? INPUT_FRAC_BITS + 1 : STQ_GW;
    localparam int SH    = 32 - INPUT_FRAC_BITS;
    localparam int LW    = ((STQ_GW + SH > 34) ? STQ_GW + SH : 34) + 1;
    localparam logic signed [LW-1:0] LIM_P = LW'(STQ_LIM_POS);
    localparam logic signed [LW-1:0] LIM_N = -LW'(STQ_LIM_NEG);

    assign busy = 1'b0;

    // ---------------- Stage 1: find the largest magnitude ----------------
    logic signed [15:0] c_in [4];
    logic [16:0]        m_in [4];
    logic [16:0]        best;
    logic [1:0]         idx_next;

    assign c_in[0] = comp_0;
    assign c_in[1] = comp_1;
    assign c_in[2] = comp_2;
    assign c_in[3] = comp_3;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            m_in[i] = c_in[i][15] ? 17'(-17'(c_in[i])) : 17'(c_in[i]);
    end

    // Later index wins a tie unless it is negative
    always_comb
    begin
        best     = m_in[0];
        idx_next = 2'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (m_in[i] > best || (m_in[i] == best && !c_in[i][15]))
            begin
                best     = m_in[i];
                idx_next = 2'(i);
            end
        end
    end

    logic               s1_vld_reg;
    logic [1:0]         s1_idx_reg;
    logic signed [15:0] s1_c_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= idx_next;
        for (int i = 0; i < 4; i++)
            s1_c_reg[i] <= c_in[i];
    end

    // ---------------- Stage 2: drop, negate, check limits ----------------
    logic signed [15:0]       r_c  [3];
    logic signed [STQ_GW-1:0] g_w  [3];
    logic signed [LW-1:0]     g_sh [3];
    logic                     neg;
    logic                     any_pos;
    logic                     any_neg;
    logic [STQ_GW-1:0]        pos_mag;
    logic [STQ_GW-1:0]        neg_mag;
    logic [STQ_KW-1:0]        k_next;
    logic [DIV_W-1:0]         vmag_next;

    assign neg = s1_c_reg[s1_idx_reg][15];

    // Keep the three remaining components in index order
    always_comb
    begin
        case (s1_idx_reg)
            2'd0:
            begin
                r_c[0] = s1_c_reg[1]; r_c[1] = s1_c_reg[2]; r_c[2] = s1_c_reg[3];
            end
            2'd1:
            begin
                r_c[0] = s1_c_reg[0]; r_c[1] = s1_c_reg[2]; r_c[2] = s1_c_reg[3];
            end
            2'd2:
            begin
                r_c[0] = s1_c_reg[0]; r_c[1] = s1_c_reg[1]; r_c[2] = s1_c_reg[3];
            end
            default:
            begin
                r_c[0] = s1_c_reg[0]; r_c[1] = s1_c_reg[1]; r_c[2] = s1_c_reg[2];
            end
        endcase
    end

    // Negative-limit violators override positive ones; the last one decides
    always_comb
    begin
        any_pos = 1'b0;
        any_neg = 1'b0;
        pos_mag = '0;
        neg_mag = '0;
        for (int i = 0; i < 3; i++)
        begin
            g_w[i]  = neg ? -STQ_GW'(r_c[i]) : STQ_GW'(r_c[i]);
            g_sh[i] = LW'(g_w[i]) <<< SH;
            if (g_sh[i] > LIM_P)
            begin
                any_pos = 1'b1;
                pos_mag = STQ_GW'(g_w[i]);
            end
            if (g_sh[i] < LIM_N)
            begin
                any_neg = 1'b1;
                neg_mag = STQ_GW'(-g_w[i]);
            end
        end
        if (any_neg)
        begin
            k_next    = STQ_KNEG;
            vmag_next = DIV_W'(neg_mag);
        end
        else if (any_pos)
        begin
            k_next    = STQ_KPOS;
            vmag_next = DIV_W'(pos_mag);
        end
        else
        begin
            k_next    = STQ_SCALE;
            vmag_next = DIV_W'(1) << INPUT_FRAC_BITS;
        end
    end

    logic                     s2_vld_reg;
    logic [1:0]               s2_idx_reg;
    logic signed [STQ_GW-1:0] s2_g_reg [3];
    logic [STQ_KW-1:0]        s2_k_reg;
    logic [DIV_W-1:0]         s2_vmag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_idx_reg  <= s1_idx_reg;
        s2_k_reg    <= k_next;
        s2_vmag_reg <= vmag_next;
        for (int i = 0; i < 3; i++)
            s2_g_reg[i] <= g_w[i];
    end

    // ---------------- Lanes ----------------
    logic [8:0] code [3];

    genvar l;
    generate
        for (l = 0; l < 3; l++)
        begin : g_lane
            stq_lane #(
                .DIV_W (DIV_W)
            ) u_lane (
                .clk  (clk),
                .g    (s2_g_reg[l]),
                .k    (s2_k_reg),
                .vmag (s2_vmag_reg),
                .code (code[l])
            );
        end
    endgenerate

    // Advance valid and index alongside the lanes
    logic       vld_reg [STQ_LANE_LAT];
    logic [1:0] idx_reg [STQ_LANE_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STQ_LANE_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= s2_vld_reg;
            for (int i = 1; i < STQ_LANE_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg[0] <= s2_idx_reg;
        for (int i = 1; i < STQ_LANE_LAT; i++)
            idx_reg[i] <= idx_reg[i-1];
    end

    assign done       = vld_reg[STQ_LANE_LAT-1];
    assign drop_index = idx_reg[STQ_LANE_LAT-1];
    assign small_a    = code[0];
    assign small_b    = code[1];
    assign small_c    = code[2];

endmodule
